@@ rtl/rcre_pkg.sv @@
// Shared types and constants of the rectangle coverage run extractor.
// Used by every module of the block; depends on nothing.
package rcre_pkg;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;
  localparam int SPAN_M_W   = 6;
  localparam int SPAN_L_W   = 7;
  localparam int IDX_W      = 6;
  localparam int CUR_W      = 5;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_EXCL  = 2'd1,
    ACT_FETCH = 2'd2
  } action_t;

  typedef struct packed {
    logic [8:0] layer_count;
    logic [7:0] layer_first;
    logic [4:0] mip_count;
    logic [3:0] mip_first;
  } req_t;

  typedef struct packed {
    logic [6:0] run_length;
    logic [8:0] run_layer;
    logic [3:0] run_mip;
  } res_t;

  typedef struct packed {
    logic load;
    logic init;
    logic excl_prep;
    logic excl_step;
    logic scan_step;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic excl_empty;
    logic excl_more;
    logic scan_done;
    logic scan_hit;
  } status_t;

endpackage

@@ rtl/rcre_dpath.sv @@
// Datapath: coverage bitmap rows, rectangle origin/span, row cursor and result registers.
// Depends on rcre_pkg; driven by rcre_ctrl through cmd_t / status_t.
module rcre_dpath import rcre_pkg::*; #(
  parameter int MAX_MIPS   = 16,
  parameter int MAX_LAYERS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  cmd_t                  cmd,
  output status_t               status,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  localparam int RW = (MAX_MIPS > 1) ? $clog2(MAX_MIPS) : 1;
  localparam logic [SPAN_M_W-1:0] MIPS_LIM   = SPAN_M_W'(MAX_MIPS);
  localparam logic [8:0]          LAYERS_LIM = 9'(MAX_LAYERS);

  req_t                    req_r;
  logic [MAX_LAYERS-1:0]   rows_r [MAX_MIPS];
  logic [3:0]              org_mip_r;
  logic [7:0]              org_layer_r;
  logic [SPAN_M_W-1:0]     span_mips_r;
  logic [SPAN_L_W-1:0]     span_layers_r;
  logic [CUR_W-1:0]        cursor_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W-1:0]        x1_r;
  logic [MAX_LAYERS-1:0]   mask_r;
  logic [MAX_LAYERS-1:0]   row_r;
  logic [SPAN_L_W-1:0]     j_r;
  res_t                    res_r;
  logic                    res_found_r;
  res_t                    out_r;
  logic                    out_found_r;

  logic [MAX_LAYERS-1:0]   cur_row;
  logic [SPAN_L_W-1:0]     first_set;
  logic [MAX_LAYERS-1:0]   ext_row;
  logic [SPAN_L_W-1:0]     run_end;
  logic [MAX_LAYERS-1:0]   new_row;
  logic [SPAN_M_W-1:0]     init_mips;
  logic [SPAN_L_W-1:0]     init_layers;
  logic [MAX_LAYERS-1:0]   init_row;
  logic [3:0]              x0;
  logic [6:0]              x1, req_x1, org_x1;
  logic [7:0]              y0;
  logic [9:0]              y1, req_y1, org_y1;
  logic [SPAN_L_W-1:0]     y0_rel, y1_rel;
  logic [MAX_LAYERS-1:0]   mask_nxt;

  assign cur_row = rows_r[idx_r[RW-1:0]];

  // first covered layer of the row under the index
  always_comb begin
    first_set = '0;
    for (int k = MAX_LAYERS - 1; k >= 0; k--) begin
      if (cur_row[k]) first_set = SPAN_L_W'(k);
    end
  end

  // end of the run: first uncovered layer at or above j
  always_comb begin
    run_end = SPAN_L_W'(MAX_LAYERS);
    for (int k = 0; k < MAX_LAYERS; k++) begin
      ext_row[k] = row_r[k] | (SPAN_L_W'(k) < j_r);
    end
    for (int k = MAX_LAYERS - 1; k >= 0; k--) begin
      if (!ext_row[k]) run_end = SPAN_L_W'(k);
    end
    for (int k = 0; k < MAX_LAYERS; k++) begin
      new_row[k] = row_r[k] & (SPAN_L_W'(k) >= run_end);
    end
  end

  // init clamp
  always_comb begin
    init_mips   = (SPAN_M_W'(req_r.mip_count) < MIPS_LIM) ? SPAN_M_W'(req_r.mip_count)
                                                          : MIPS_LIM;
    init_layers = (req_r.layer_count < LAYERS_LIM) ? SPAN_L_W'(req_r.layer_count)
                                                   : SPAN_L_W'(LAYERS_LIM);
    for (int k = 0; k < MAX_LAYERS; k++) begin
      init_row[k] = SPAN_L_W'(k) < init_layers;
    end
  end

  // exclude overlap
  always_comb begin
    x0     = (req_r.mip_first > org_mip_r) ? req_r.mip_first : org_mip_r;
    req_x1 = 7'(req_r.mip_first) + 7'(req_r.mip_count);
    org_x1 = 7'(org_mip_r) + 7'(span_mips_r);
    x1     = (req_x1 > org_x1) ? org_x1 : req_x1;
    y0     = (req_r.layer_first > org_layer_r) ? req_r.layer_first : org_layer_r;
    req_y1 = 10'(req_r.layer_first) + 10'(req_r.layer_count);
    org_y1 = 10'(org_layer_r) + 10'(span_layers_r);
    y1     = (req_y1 > org_y1) ? org_y1 : req_y1;
    y0_rel = SPAN_L_W'(10'(y0) - 10'(org_layer_r));
    y1_rel = SPAN_L_W'(y1 - 10'(org_layer_r));
    for (int k = 0; k < MAX_LAYERS; k++) begin
      mask_nxt[k] = (SPAN_L_W'(k) >= y0_rel) && (SPAN_L_W'(k) < y1_rel);
    end
  end

  assign status.excl_empty = (7'(x0) >= x1) || (10'(y0) >= y1);
  assign status.excl_more  = idx_r < x1_r;
  assign status.scan_done  = idx_r >= IDX_W'(span_mips_r);
  assign status.scan_hit   = !status.scan_done && (|cur_row);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_MIPS; i++) rows_r[i] <= '0;
      org_mip_r     <= '0;
      org_layer_r   <= '0;
      span_mips_r   <= '0;
      span_layers_r <= '0;
      cursor_r      <= '0;
    end else begin
      if (cmd.init) begin
        for (int i = 0; i < MAX_MIPS; i++) begin
          rows_r[i] <= (SPAN_M_W'(i) < init_mips) ? init_row : '0;
        end
        org_mip_r     <= req_r.mip_first;
        org_layer_r   <= req_r.layer_first;
        span_mips_r   <= init_mips;
        span_layers_r <= init_layers;
        cursor_r      <= '0;
      end
      if (cmd.excl_step && status.excl_more) begin
        rows_r[idx_r[RW-1:0]] <= cur_row & ~mask_r;
      end
      if (cmd.finish) begin
        rows_r[idx_r[RW-1:0]] <= new_row;
        if (new_row == '0) cursor_r <= CUR_W'(idx_r + IDX_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_t'(in_tdata[$bits(req_t)-1:0]);
      idx_r <= IDX_W'(cursor_r);
    end
    if (cmd.excl_prep) begin
      idx_r  <= IDX_W'(x0 - org_mip_r);
      x1_r   <= IDX_W'(x1 - 7'(org_mip_r));
      mask_r <= mask_nxt;
    end
    if (cmd.excl_step && status.excl_more) idx_r <= idx_r + IDX_W'(1);
    if (cmd.scan_step) begin
      if (status.scan_done) begin
        res_found_r <= 1'b0;
        res_r       <= '0;
      end else if (status.scan_hit) begin
        row_r <= cur_row;
        j_r   <= first_set;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
    if (cmd.finish) begin
      res_found_r      <= 1'b1;
      res_r.run_mip    <= org_mip_r + idx_r[3:0];
      res_r.run_layer  <= 9'(org_layer_r) + 9'(j_r);
      res_r.run_length <= run_end - j_r;
    end
    if (cmd.emit) begin
      out_r       <= res_r;
      out_found_r <= res_found_r;
    end
  end

  assign out_tdata = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, out_r};
  assign out_tuser = out_found_r;

endmodule

@@ rtl/rcre_ctrl.sv @@
// Controller state machine: request acceptance, row walk sequencing, result handshake.
// Depends on rcre_pkg; commands rcre_dpath through cmd_t / status_t.
module rcre_ctrl import rcre_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_USER_W-1:0] in_action,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output cmd_t                 cmd,
  input  status_t              status
);

  typedef enum logic [2:0] {
    IDLE,
    INIT,
    EXCL_PREP,
    EXCL_WALK,
    SCAN,
    FIND,
    RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          case (in_action)
            ACT_INIT:  state_nxt = INIT;
            ACT_EXCL:  state_nxt = EXCL_PREP;
            ACT_FETCH: state_nxt = SCAN;
            default:   state_nxt = IDLE;
          endcase
        end
      end
      INIT: begin
        cmd.init  = 1'b1;
        state_nxt = IDLE;
      end
      EXCL_PREP: begin
        cmd.excl_prep = 1'b1;
        state_nxt     = status.excl_empty ? IDLE : EXCL_WALK;
      end
      EXCL_WALK: begin
        cmd.excl_step = 1'b1;
        if (!status.excl_more) state_nxt = IDLE;
      end
      SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done)     state_nxt = RESULT;
        else if (status.scan_hit) state_nxt = FIND;
      end
      FIND: begin
        cmd.finish = 1'b1;
        state_nxt  = RESULT;
      end
      RESULT: begin
        if (!out_tvalid_r || out_tready) begin
          cmd.emit  = 1'b1;
          state_nxt = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit)        out_tvalid_nxt = 1'b1;
    else if (out_tready) out_tvalid_nxt = 1'b0;
    else                 out_tvalid_nxt = out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

endmodule

@@ rtl/rect_coverage_run_extractor.sv @@
// Rectangle coverage run extractor, top level.
// Depends on rcre_pkg, rcre_ctrl and rcre_dpath.
//
// Keeps a coverage bitmap of MAX_MIPS rows (mip levels) by MAX_LAYERS bits
// (array layers). Requests arrive on the in_ stream: in_tuser carries the
// action (init, exclude, fetch), in_tdata the rectangle. Init covers the
// clamped rectangle and rewinds the row cursor; exclude uncovers the overlap
// with a second rectangle; fetch emits and uncovers the first run of covered
// layers at or after the cursor row. Only fetch produces a result on out_.
// One request is in work at a time; in_tready is high only while idle.
// Per request: init loads, then covers; exclude loads and clips the overlap, then, if
// there is one, uncovers the overlapped rows one by one; fetch loads, scans rows from
// the cursor (empty rows skipped), finds the run and emits, a single bitmap row read per cycle.
// The result sits in an output register: a stalled receiver holds it while
// the next request is taken; a further fetch then waits for that slot.
// Synchronous active-low reset clears the bitmap, origin, spans, cursor
// and the output valid.
module rect_coverage_run_extractor import rcre_pkg::*; #(
  parameter int MAX_MIPS   = 16,
  parameter int MAX_LAYERS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // mip_first, mip_count, layer_first, layer_count
  input  logic [IN_USER_W-1:0]  in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // run_mip, run_layer, run_length
  output logic                  out_tuser   // found
);

  cmd_t    cmd;
  status_t status;

  rcre_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status)
  );

  rcre_dpath #(
    .MAX_MIPS   (MAX_MIPS),
    .MAX_LAYERS (MAX_LAYERS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

@@ rtl/rcre_checker.sv @@
// Port-level checker for the rectangle coverage run extractor, bound to the top level.
// Depends on rcre_pkg.
module rcre_checker import rcre_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [IN_USER_W-1:0]  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // unknown actions return to idle at once
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == ACT_INIT || in_tuser == ACT_EXCL || in_tuser == ACT_FETCH) |=> !in_tready)
    else $error("request taken while previous one still in work");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("empty result carries nonzero fields");

  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[19:13] != 7'd0)
    else $error("found run with zero length");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind rect_coverage_run_extractor rcre_checker u_rcre_checker (.*);
